// File: rtl/utf8_decode_classify_core_macros.svh
// Assertion helpers for the UTF-8 decode and classify block.
`ifndef UTF8_DECODE_CLASSIFY_CORE_MACROS_SVH
`define UTF8_DECODE_CLASSIFY_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define U8DC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("u8dc same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define U8DC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("u8dc next-cycle check failed");

`endif

// File: rtl/u8dc_pkg.sv
`default_nettype none
package u8dc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned PEND_W = 2;
    localparam int unsigned SC_W   = 2;

    // Script class codes
    localparam logic [SC_W-1:0] SC_LATIN    = 2'd0;
    localparam logic [SC_W-1:0] SC_ARABIC   = 2'd1;
    localparam logic [SC_W-1:0] SC_HEBREW   = 2'd2;
    localparam logic [SC_W-1:0] SC_CYRILLIC = 2'd3;

    // Lead byte patterns
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_VAL  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_VAL  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_VAL  = 8'hF0;

    // Range bounds
    localparam logic [CP_W-1:0] HEB_LO  = 21'h000590;
    localparam logic [CP_W-1:0] HEB_HI  = 21'h0005FF;
    localparam logic [CP_W-1:0] ARA1_LO = 21'h000600;
    localparam logic [CP_W-1:0] ARA1_HI = 21'h0006FF;
    localparam logic [CP_W-1:0] ARA2_LO = 21'h000750;
    localparam logic [CP_W-1:0] ARA2_HI = 21'h00077F;
    localparam logic [CP_W-1:0] ARA3_LO = 21'h0008A0;
    localparam logic [CP_W-1:0] ARA3_HI = 21'h0008FF;
    localparam logic [CP_W-1:0] CYR_LO  = 21'h000400;
    localparam logic [CP_W-1:0] CYR_HI  = 21'h0004FF;

    // Decoder output toward the classify/output stage
    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] cp;
        logic            last;
    } t_dec_res;

    // Decoder status for checking
    typedef struct packed {
        logic [PEND_W-1:0] pending;
    } t_dec_stat;

endpackage
`default_nettype wire

// File: rtl/u8dc_decode.sv
`default_nettype none
module u8dc_decode
    import u8dc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic              i_last,
    output t_dec_res               o_res,
    output t_dec_stat              o_stat
);

    logic [PEND_W-1:0] r_pending, n_pending;
    logic [CP_W-1:0]   r_partial, n_partial;
    logic [CP_W-1:0]   cont_bits;
    logic [CP_W-1:0]   lead_cp;
    logic              lead_ok;
    t_dec_res          res;

    // Continuation payload placed by bytes still expected
    always_comb begin
        case (r_pending)
            2'd1:    cont_bits = {15'b0, i_byte[5:0]};
            2'd2:    cont_bits = {9'b0, i_byte[5:0], 6'b0};
            default: cont_bits = {3'b0, i_byte[5:0], 12'b0};
        endcase
    end

    // Decode one byte against the pending state
    always_comb begin
        n_pending = r_pending;
        n_partial = r_partial;
        res.emit  = 1'b0;
        res.cp    = '0;
        res.last  = i_last;
        lead_cp   = '0;
        lead_ok   = 1'b1;
        if (r_pending == '0) begin
            if (!i_byte[7]) begin
                res.emit = 1'b1;
                res.cp   = {13'b0, i_byte};
                lead_ok  = 1'b0;
            end else if ((i_byte & LEAD2_MASK) == LEAD2_VAL) begin
                lead_cp   = {10'b0, i_byte[4:0], 6'b0};
                n_pending = 2'd1;
            end else if ((i_byte & LEAD3_MASK) == LEAD3_VAL) begin
                lead_cp   = {5'b0, i_byte[3:0], 12'b0};
                n_pending = 2'd2;
            end else if ((i_byte & LEAD4_MASK) == LEAD4_VAL) begin
                lead_cp   = {i_byte[2:0], 18'b0};
                n_pending = 2'd3;
            end else begin
                // stray or invalid lead gives zero
                res.emit = 1'b1;
                lead_ok  = 1'b0;
            end
            if (lead_ok) begin
                if (i_last) begin
                    res.emit  = 1'b1;
                    res.cp    = lead_cp;
                    n_pending = '0;
                    n_partial = '0;
                end else begin
                    n_partial = lead_cp;
                end
            end
        end else begin
            n_pending = r_pending - 2'd1;
            if (n_pending == '0 || i_last) begin
                res.emit  = 1'b1;
                res.cp    = r_partial | cont_bits;
                n_pending = '0;
                n_partial = '0;
            end else begin
                n_partial = r_partial | cont_bits;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_partial <= '0;
        end else if (i_adv) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
        end
    end

    assign o_res          = res;
    assign o_stat.pending = r_pending;

endmodule
`default_nettype wire

// File: rtl/u8dc_classify.sv
`default_nettype none
module u8dc_classify
    import u8dc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_adv,
    input  wire t_dec_res  i_res,
    input  wire logic      i_m_axis_tready,
    output logic           o_m_axis_tvalid,
    output logic [23:0]    o_m_axis_tdata,
    output logic [3:0]     o_m_axis_tuser,
    output logic           o_m_axis_tlast,
    output logic           o_free
);

    logic              r_valid;
    logic [CP_W-1:0]   r_cp;
    logic [SC_W-1:0]   r_sc;
    logic              r_rtl;
    logic              r_bidi;
    logic              r_last;
    logic [SC_W-1:0]   sc;
    logic              load;

    // Script range lookup
    always_comb begin
        if ((i_res.cp >= ARA1_LO && i_res.cp <= ARA1_HI) ||
            (i_res.cp >= ARA2_LO && i_res.cp <= ARA2_HI) ||
            (i_res.cp >= ARA3_LO && i_res.cp <= ARA3_HI)) begin
            sc = SC_ARABIC;
        end else if (i_res.cp >= HEB_LO && i_res.cp <= HEB_HI) begin
            sc = SC_HEBREW;
        end else if (i_res.cp >= CYR_LO && i_res.cp <= CYR_HI) begin
            sc = SC_CYRILLIC;
        end else begin
            sc = SC_LATIN;
        end
    end

    assign o_free = !r_valid || i_m_axis_tready;
    assign load   = i_adv && i_res.emit;

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= load;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp   <= i_res.cp;
            r_sc   <= sc;
            r_rtl  <= (sc == SC_ARABIC) || (sc == SC_HEBREW);
            r_bidi <= (i_res.cp >= HEB_LO) && (i_res.cp <= ARA1_HI);
            r_last <= i_res.last;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {3'b0, r_cp};
    assign o_m_axis_tuser  = {r_bidi, r_rtl, r_sc};
    assign o_m_axis_tlast  = r_last;

endmodule
`default_nettype wire

// File: rtl/utf8_decode_classify_core.sv
// Channel  | Dir | tdata bits (low up)      | tuser bits (low up)                | tlast
// s_axis   | in  | text_byte[7:0]           | -                                  | end_of_text
// m_axis   | out | code_point[20:0], 0 pad  | script_class[1:0], rtl[2], bidi[3] | final_point
//
// One byte per clock sustained while the output is not stalled.
// Latency is set by the input register and the result register around the decode logic.
// i_rst_n is synchronous, active low; it clears valids and the pending sequence state.
// A stalled output holds its result; the input register keeps taking bytes while the
// result register is free or being drained in the same cycle.
`default_nettype none
`include "utf8_decode_classify_core_macros.svh"
module utf8_decode_classify_core
    import u8dc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // text_byte[7:0]
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // code_point[20:0], zeros[23:21]
    output logic [3:0]       o_m_axis_tuser,   // script_class[1:0], right_to_left, bidi_level
    output logic             o_m_axis_tlast
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              out_free;
    logic              adv;
    t_dec_res          dec_res;
    t_dec_stat         dec_stat;
    logic              in_done;
    logic              out_cp_mid;

    assign adv             = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    u8dc_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (dec_res),
        .o_stat  (dec_stat)
    );

    u8dc_classify u_classify (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_res           (dec_res),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_free          (out_free)
    );

    // Checks
    assign in_done    = adv && r_in_last;
    assign out_cp_mid = (o_m_axis_tdata[CP_W-1:0] >= HEB_LO) &&
                        (o_m_axis_tdata[CP_W-1:0] <= ARA1_HI);

    `U8DC_ASSERT_NEXT(a_last_clears_state, i_clk, i_rst_n, in_done, dec_stat.pending == '0)
    `U8DC_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, in_done, o_m_axis_tvalid && o_m_axis_tlast)
    `U8DC_ASSERT_NOW(a_bidi_range, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[3], out_cp_mid)

endmodule
`default_nettype wire

// File: tb/sv/utf8_point_checker.sv
`timescale 1ns / 1ps
// Watches both stream channels of the UTF-8 decode/classify block, predicts the
// code points and classes from accepted bytes and compares results in order.
module utf8_point_checker
    import u8dc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // text_byte[7:0]
    input  logic        i_s_tlast,    // end_of_text
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,    // code_point[20:0], zeros[23:21]
    input  logic [3:0]  i_m_tuser,    // script_class[1:0], right_to_left, bidi_level
    input  logic        i_m_tlast,    // final_point
    output int          o_fail_count,
    output int          o_points_due
);

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic [SC_W-1:0] script_class;
        logic            right_to_left;
        logic            bidi_level;
        logic            final_point;
    } t_point;

    // Decoder state: continuation bytes still owed and bits gathered so far
    logic [PEND_W-1:0] seq_left = '0;
    logic [CP_W-1:0]   seq_bits = '0;
    t_point            points_q[$];
    int                fails = 0;

    // Script class, direction and bidi level of one code point
    function automatic t_point classify_point(input logic [CP_W-1:0] cp, input logic fin);
        t_point p;
        p.code_point  = cp;
        p.final_point = fin;
        if ((cp >= ARA1_LO && cp <= ARA1_HI) || (cp >= ARA2_LO && cp <= ARA2_HI) ||
            (cp >= ARA3_LO && cp <= ARA3_HI)) begin
            p.script_class = SC_ARABIC;
        end else if (cp >= HEB_LO && cp <= HEB_HI) begin
            p.script_class = SC_HEBREW;
        end else if (cp >= CYR_LO && cp <= CYR_HI) begin
            p.script_class = SC_CYRILLIC;
        end else begin
            p.script_class = SC_LATIN;
        end
        p.right_to_left = (p.script_class == SC_ARABIC) || (p.script_class == SC_HEBREW);
        p.bidi_level    = (cp >= HEB_LO) && (cp <= ARA1_HI);
        return p;
    endfunction

    // Append one predicted point at the tail of the queue
    task automatic add_point(input logic [CP_W-1:0] cp, input logic fin);
        points_q.insert(points_q.size(), classify_point(cp, fin));
    endtask

    // Lenient decode of one accepted byte; queues a point when one is due
    task automatic decode_byte(input logic [7:0] text_b, input logic fin);
        logic [CP_W-1:0]   acc;
        logic [PEND_W-1:0] need;
        acc  = '0;
        need = '0;
        if (seq_left == '0) begin
            if (!text_b[7]) begin
                add_point({{(CP_W-8){1'b0}}, text_b}, fin);
            end else if ((text_b & LEAD2_MASK) == LEAD2_VAL) begin
                acc  = {{(CP_W-11){1'b0}}, text_b[4:0], 6'b0};
                need = 2'd1;
            end else if ((text_b & LEAD3_MASK) == LEAD3_VAL) begin
                acc  = {{(CP_W-16){1'b0}}, text_b[3:0], 12'b0};
                need = 2'd2;
            end else if ((text_b & LEAD4_MASK) == LEAD4_VAL) begin
                acc  = {text_b[2:0], 18'b0};
                need = 2'd3;
            end else begin
                // stray continuation or invalid lead
                add_point('0, fin);
            end
            if (need != '0) begin
                if (fin) begin
                    // string ends right on the lead byte
                    add_point(acc, 1'b1);
                end else begin
                    seq_left = need;
                    seq_bits = acc;
                end
            end
        end else begin
            // any byte counts as continuation here; low six bits at their place
            acc = seq_bits | ({{(CP_W-6){1'b0}}, text_b[5:0]} << (6 * (seq_left - 1)));
            if (seq_left == 2'd1 || fin) begin
                add_point(acc, fin);
                seq_left = '0;
                seq_bits = '0;
            end else begin
                seq_left = seq_left - 2'd1;
                seq_bits = acc;
            end
        end
    endtask

    task automatic note_field(input string what, input int unsigned want, input int unsigned got);
        if (want != got) begin
            fails++;
            if (fails <= 10) begin
                $display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
            end
        end
    endtask

    // Compare one accepted result with the oldest prediction
    task automatic check_point();
        t_point want;
        if (points_q.size() == 0) begin
            fails++;
            if (fails <= 10) begin
                $display("[%0t] unexpected item: code point %0h", $realtime, i_m_tdata);
            end
        end else begin
            want = points_q.pop_front();
            note_field("code_point", want.code_point, i_m_tdata[CP_W-1:0]);
            note_field("tdata pad", 0, i_m_tdata[23:CP_W]);
            note_field("script_class", want.script_class, i_m_tuser[1:0]);
            note_field("right_to_left", want.right_to_left, i_m_tuser[2]);
            note_field("bidi_level", want.bidi_level, i_m_tuser[3]);
            note_field("final_point", want.final_point, i_m_tlast);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_left = '0;
            seq_bits = '0;
            points_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_point();
            end
            if (i_s_tvalid && i_s_tready) begin
                decode_byte(i_s_tdata, i_s_tlast);
            end
        end
        o_fail_count <= fails;
        o_points_due <= points_q.size();
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import u8dc_pkg::*;

    localparam int ITEM_COUNT  = 950;
    localparam int CALM_FROM   = 800;
    localparam int STALL_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // text_byte[7:0]
    logic        s_tlast;     // end_of_text
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;     // code_point[20:0], zeros[23:21]
    logic [3:0]  m_tuser;     // script_class[1:0], right_to_left, bidi_level
    logic        m_tlast;     // final_point
    int          fail_count;
    int          points_due;

    logic        src_idle_on = 1'b0;
    logic        snk_idle_on = 1'b0;
    int          bytes_sent  = 0;
    int          phase       = -1;
    logic [7:0]  text_q[$];

    // {end_of_text, byte}: single bytes, stray and invalid leads, full 2/3/4-byte
    // sequences, a non-10 continuation, and strings cut off mid-sequence
    logic [8:0] opening_text [0:24] = '{
        9'h000, 9'h07F, 9'h080, 9'h0FF, 9'h0F8, 9'h0BF,
        9'h0DF, 9'h0BF, 9'h0D7, 9'h090, 9'h0D8, 9'h0A7,
        9'h0E0, 9'h0A2, 9'h0A0, 9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
        9'h0C1, 9'h000, 9'h0E2, 9'h182, 9'h1F0, 9'h141
    };

    // Code points on both sides of every class boundary
    int unsigned edge_points [0:17] = '{
        'h3FF, 'h400, 'h4FF, 'h500, 'h58F, 'h590, 'h5FF, 'h600, 'h6FF,
        'h700, 'h74F, 'h750, 'h77F, 'h780, 'h89F, 'h8A0, 'h8FF, 'h900
    };

    utf8_decode_classify_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    utf8_point_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_points_due (points_due)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one byte, with an occasional gap ahead of it, and wait for acceptance
    task automatic send_byte(input logic [7:0] text_b, input logic fin);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= text_b;
        s_tlast  <= fin;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    // Append one byte at the tail of the pending text
    task automatic add_text(input logic [7:0] text_b);
        text_q.insert(text_q.size(), text_b);
    endtask

    // One character's bytes: mostly encoded code points (some overlong, some with
    // bad continuation tags), otherwise a lone random byte
    task automatic fill_text();
        logic [20:0] cp;
        logic [7:0]  noise;
        logic [1:0]  tag;
        int          need;
        int          len;
        text_q.delete();
        if ($urandom_range(0, 4) == 0) begin
            noise = 8'($urandom_range(0, 255));
            add_text(noise);
        end else begin
            case ($urandom_range(0, 9))
                0, 1: cp = 21'($urandom_range(0, 'h7F));
                2: cp = 21'($urandom_range(CYR_LO, CYR_HI));
                3: cp = 21'($urandom_range(HEB_LO, HEB_HI));
                4: cp = 21'($urandom_range(ARA1_LO, ARA1_HI));
                5: cp = 21'($urandom_range(0, 1) ? $urandom_range(ARA2_LO, ARA2_HI)
                                                 : $urandom_range(ARA3_LO, ARA3_HI));
                6: cp = 21'(edge_points[$urandom_range(0, 17)]);
                7: cp = 21'($urandom_range('h80, 'h7FF));
                8: cp = 21'($urandom_range('h800, 'hFFFF));
                default: cp = 21'($urandom_range('h10000, 'h1FFFFF));
            endcase
            need = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
            len  = ($urandom_range(0, 6) == 0) ? int'($urandom_range(need, 4)) : need;
            case (len)
                1: add_text({1'b0, cp[6:0]});
                2: add_text({3'b110, cp[10:6]});
                3: add_text({4'b1110, cp[15:12]});
                default: add_text({5'b11110, cp[20:18]});
            endcase
            for (int k = len - 2; k >= 0; k--) begin
                tag = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
                add_text({tag, cp[6*k +: 6]});
            end
        end
    endtask

    // Result side: random stall bursts while enabled
    initial begin
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (snk_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no item moving
    initial begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n    <= 1'b1;
        m_tready <= 1'b1;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;

        foreach (opening_text[i]) begin
            send_byte(opening_text[i][7:0], opening_text[i][8]);
        end

        // random text; idling re-rolled every hundred bytes, none near the end
        while (bytes_sent < ITEM_COUNT) begin
            if (bytes_sent >= CALM_FROM) begin
                src_idle_on = 1'b0;
                snk_idle_on = 1'b0;
            end else if (bytes_sent / 100 != phase) begin
                phase       = bytes_sent / 100;
                src_idle_on = ($urandom_range(0, 2) != 0);
                snk_idle_on = ($urandom_range(0, 2) != 0);
            end
            fill_text();
            foreach (text_q[i]) begin
                send_byte(text_q[i], $urandom_range(0, 11) == 0);
            end
        end
        s_tvalid <= 1'b0;

        // drain outstanding results, then watch for stray ones
        repeat (2) @(posedge clk);
        while (points_due != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && points_due == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/u8dc_pkg.sv
rtl/u8dc_decode.sv
rtl/u8dc_classify.sv
rtl/utf8_decode_classify_core.sv
tb/sv/utf8_point_checker.sv
tb/sv/tb_top.sv
